@@ rtl/kvc_pkg.sv @@
// shared types, constants and the quadrature transition table for the knob volume controller
`timescale 1ns / 1ps
`default_nettype none
package kvc_pkg;

  localparam int unsigned VOL_W      = 7;
  localparam int unsigned OPA_W      = 8;
  localparam int unsigned GAP_W      = 10;
  localparam int unsigned HOLD_W     = 16;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned COUNT_W    = 32;
  localparam int unsigned DETENT_W   = COUNT_W - 2;
  localparam int unsigned DIFF_W     = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 24;

  localparam logic [VOL_W-1:0] VOL_MAX   = 7'd100;
  localparam logic [VOL_W-1:0] VOL_RESET = 7'd25;
  localparam logic [OPA_W-1:0] OPA_MAX   = 8'd255;

  // multiplier codes picked from the gap since the last detent change
  localparam logic signed [4:0] MULT_FAST   = 5'sd10;
  localparam logic signed [4:0] MULT_MEDIUM = 5'sd5;
  localparam logic signed [4:0] MULT_SLOW   = 5'sd2;
  localparam logic signed [4:0] MULT_UNIT   = 5'sd1;

  // history {prev_a, prev_b, a, b} to quarter step
  localparam logic signed [1:0] STEP_TABLE [0:15] = '{
    2'sd0, -2'sd1,  2'sd1,  2'sd0,
    2'sd1,  2'sd0,  2'sd0, -2'sd1,
   -2'sd1,  2'sd0,  2'sd0,  2'sd1,
    2'sd0,  2'sd1, -2'sd1,  2'sd0
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FAST_GAP   = 3'd0,
    CFG_MEDIUM_GAP = 3'd1,
    CFG_SLOW_GAP   = 3'd2,
    CFG_SHOW_HOLD  = 3'd3,
    CFG_FADE_IN    = 3'd4,
    CFG_FADE_OUT   = 3'd5
  } cfg_index_t;

  typedef struct packed {
    logic [GAP_W-1:0]  fast_gap;
    logic [GAP_W-1:0]  medium_gap;
    logic [GAP_W-1:0]  slow_gap;
    logic [HOLD_W-1:0] show_hold;
    logic [OPA_W-1:0]  fade_in_step;
    logic [OPA_W-1:0]  fade_out_step;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    fast_gap:      10'd50,
    medium_gap:    10'd120,
    slow_gap:      10'd250,
    show_hold:     16'd2000,
    fade_in_step:  8'd51,
    fade_out_step: 8'd25
  };

  // detent event from the decoder; diff saturated to a range that still clamps the same
  typedef struct packed {
    logic                     changed;
    logic signed [DIFF_W-1:0] diff;
  } detent_evt_t;

  typedef struct packed {
    logic             popup_visible;
    logic [OPA_W-1:0] popup_opacity;
    logic             mute_on;
    logic             volume_changed;
    logic [VOL_W-1:0] volume_level;
  } result_t;

endpackage
`default_nettype wire

@@ rtl/kvc_decode.sv @@
// quadrature decoder: pin history, quarter count and detent change detection
`timescale 1ns / 1ps
`default_nettype none
module kvc_decode (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire logic                 pin_a,
  input  wire logic                 pin_b,
  output kvc_pkg::detent_evt_t      evt
);
  import kvc_pkg::*;

  logic [3:0]                 hist_r, hist_nxt;
  logic [COUNT_W-1:0]         quarter_r, quarter_nxt;
  logic signed [DETENT_W-1:0] last_detent_r, detent_nxt;
  logic signed [DETENT_W:0]   diff_full;

  assign hist_nxt    = {hist_r[1:0], pin_a, pin_b};
  assign quarter_nxt = quarter_r + COUNT_W'($signed(STEP_TABLE[hist_nxt]));

  // divide by four toward zero: arithmetic shift, plus one for a negative with a remainder
  assign detent_nxt = $signed(quarter_nxt[COUNT_W-1:2])
                    + $signed({{(DETENT_W-1){1'b0}},
                               quarter_nxt[COUNT_W-1] & (|quarter_nxt[1:0])});

  assign diff_full = $signed({detent_nxt[DETENT_W-1], detent_nxt})
                   - $signed({last_detent_r[DETENT_W-1], last_detent_r});

  always_comb begin
    evt.changed = (detent_nxt != last_detent_r);
    if (diff_full > $signed((DETENT_W+1)'(127))) begin
      evt.diff = 8'sd127;
    end else if (diff_full < $signed(-(DETENT_W+1)'(127))) begin
      evt.diff = -8'sd127;
    end else begin
      evt.diff = diff_full[DIFF_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r        <= '0;
      quarter_r     <= '0;
      last_detent_r <= '0;
    end else if (en) begin
      hist_r        <= hist_nxt;
      quarter_r     <= quarter_nxt;
      last_detent_r <= detent_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/kvc_level.sv @@
// volume, mute, tick time and popup fade state
`timescale 1ns / 1ps
`default_nettype none
module kvc_level (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire logic                 mute_toggle,
  input  wire kvc_pkg::detent_evt_t evt,
  input  wire kvc_pkg::cfg_t        cfg,
  output kvc_pkg::result_t          res
);
  import kvc_pkg::*;

  logic [TIME_W-1:0] tick_r, last_change_r;
  logic [VOL_W-1:0]  volume_r, volume_nxt;
  logic              muted_r, muted_nxt;
  logic [OPA_W-1:0]  opacity_r, opacity_nxt;
  logic              active_r, active_nxt;
  logic [TIME_W-1:0] gap, elapsed;
  logic signed [4:0] mult;
  logic signed [12:0] delta;
  logic signed [13:0] vol_sum;
  logic [OPA_W:0]    opa_up;

  assign gap     = tick_r - last_change_r;
  assign elapsed = evt.changed ? '0 : gap;

  always_comb begin
    if (gap < TIME_W'(cfg.fast_gap)) begin
      mult = MULT_FAST;
    end else if (gap < TIME_W'(cfg.medium_gap)) begin
      mult = MULT_MEDIUM;
    end else if (gap < TIME_W'(cfg.slow_gap)) begin
      mult = MULT_SLOW;
    end else begin
      mult = MULT_UNIT;
    end
  end

  // both operands widened first so the product keeps all of its bits
  assign delta   = 13'(evt.diff) * 13'(mult);
  assign vol_sum = $signed({7'b0, volume_r}) + 14'(delta);
  assign opa_up  = {1'b0, opacity_r} + {1'b0, cfg.fade_in_step};

  always_comb begin
    volume_nxt = volume_r;
    muted_nxt  = muted_r ^ mute_toggle;
    if (evt.changed) begin
      muted_nxt = 1'b0;
      if (vol_sum > $signed({7'b0, VOL_MAX})) begin
        volume_nxt = VOL_MAX;
      end else if (vol_sum < 14'sd0) begin
        volume_nxt = '0;
      end else begin
        volume_nxt = vol_sum[VOL_W-1:0];
      end
    end
  end

  always_comb begin
    opacity_nxt = opacity_r;
    active_nxt  = active_r | evt.changed;
    if (active_nxt) begin
      if (elapsed < TIME_W'(cfg.show_hold)) begin
        if (opacity_r != OPA_MAX) begin
          opacity_nxt = opa_up[OPA_W] ? OPA_MAX : opa_up[OPA_W-1:0];
        end
      end else if (opacity_r != '0) begin
        opacity_nxt = (opacity_r > cfg.fade_out_step) ? opacity_r - cfg.fade_out_step : '0;
      end else begin
        active_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    res.volume_level   = volume_nxt;
    res.volume_changed = evt.changed;
    res.mute_on        = muted_nxt;
    res.popup_opacity  = opacity_nxt;
    res.popup_visible  = active_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r        <= '0;
      last_change_r <= '0;
      volume_r      <= VOL_RESET;
      muted_r       <= 1'b0;
      opacity_r     <= '0;
      active_r      <= 1'b0;
    end else if (en) begin
      tick_r    <= tick_r + TIME_W'(1);
      volume_r  <= volume_nxt;
      muted_r   <= muted_nxt;
      opacity_r <= opacity_nxt;
      active_r  <= active_nxt;
      if (evt.changed) begin
        last_change_r <= tick_r;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/knob_volume_controller_unit.sv @@
// top level of the knob volume controller: input register, config registers, output register
`timescale 1ns / 1ps
`default_nettype none
// knob volume controller
// one input beat is one 1 ms tick: sampled quadrature pins a/b and a mute-toggle request.
// every input beat yields exactly one output beat with volume, change flag, mute flag,
// popup opacity and popup visibility after that tick.
// channels: in_* slave stream, out_* master stream, cfg_* register write channel
// (index 0 fast gap, 1 medium gap, 2 slow gap, 3 show hold, 4 fade in, 5 fade out;
// other indexes are dropped). cfg_ready is always high; write only while idle.
// an input beat is captured in the input register, then loaded into the output register,
// which holds it on out_* until out_tready takes it.
// throughput: one beat per cycle while out_tready is high; the tick is registered, then a
// single pass of compare, add and clamp logic updates the state and loads the output register.
// stall: the output register holds its beat while out_tready is low; the input
// register still takes one more beat, then in_tready drops until out_tready returns.
// reset (rst_n low, synchronous): volume 25, mute off, popup hidden at opacity 0,
// counters cleared, registers back to their defaults, both streams empty.
module knob_volume_controller_unit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // input stream
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [kvc_pkg::IN_DATA_W-1:0]     in_tdata,   // pin_a, pin_b, mute_toggle, zero pad
  // result stream
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [kvc_pkg::OUT_DATA_W-1:0]         out_tdata,  // volume_level[6:0], volume_changed,
                                                             // mute_on, popup_opacity[7:0],
                                                             // popup_visible, zero pad
  // register writes
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [kvc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [kvc_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import kvc_pkg::*;

  cfg_t        cfg_r, cfg_nxt;
  logic        s1_valid_r;
  logic        s1_pin_a_r, s1_pin_b_r, s1_toggle_r;
  logic        advance;
  logic        out_valid_r;
  result_t     res_r;
  result_t     res;
  detent_evt_t evt;

  // tick moves from the input register into state and output register
  assign advance   = s1_valid_r & (~out_valid_r | out_tready);
  assign in_tready = ~s1_valid_r | advance;
  assign cfg_ready = 1'b1;

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_FAST_GAP:   cfg_nxt.fast_gap      = cfg_data[GAP_W-1:0];
        CFG_MEDIUM_GAP: cfg_nxt.medium_gap    = cfg_data[GAP_W-1:0];
        CFG_SLOW_GAP:   cfg_nxt.slow_gap      = cfg_data[GAP_W-1:0];
        CFG_SHOW_HOLD:  cfg_nxt.show_hold     = cfg_data[HOLD_W-1:0];
        CFG_FADE_IN:    cfg_nxt.fade_in_step  = cfg_data[OPA_W-1:0];
        CFG_FADE_OUT:   cfg_nxt.fade_out_step = cfg_data[OPA_W-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready & in_tvalid) begin
      s1_pin_a_r  <= in_tdata[0];
      s1_pin_b_r  <= in_tdata[1];
      s1_toggle_r <= in_tdata[2];
    end
  end

  kvc_decode u_decode (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (advance),
    .pin_a (s1_pin_a_r),
    .pin_b (s1_pin_b_r),
    .evt   (evt)
  );

  kvc_level u_level (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (advance),
    .mute_toggle (s1_toggle_r),
    .evt         (evt),
    .cfg         (cfg_r),
    .res         (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - $bits(result_t)){1'b0}}, res_r};

endmodule
`default_nettype wire
